// ----- src/ils_pkg.sv -----
// ----------------------------------------------------------------------------
// ils_pkg: shared types and constants for the indexed list store
// Sizes, operation and status codes, and the command word broadcast along
// the row of entry cells.
// ----------------------------------------------------------------------------
package ils_pkg;

  // Sizes
  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;
  localparam int IDX_W    = 8;
  localparam int OP_W     = 3;
  localparam int ST_W     = 2;
  localparam int LEN_W    = 7;
  localparam int CMP_W    = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;
  localparam int GRP_SIZE = 8;
  localparam int NGRP     = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  // Operation codes
  localparam logic [OP_W-1:0] OP_GET      = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
  localparam logic [OP_W-1:0] OP_INS_POS  = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

  // Status codes
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // Command broadcast to every cell
  typedef struct packed {
    logic              shift_up;
    logic              shift_down;
    logic              rd_en;
    logic [CNT_W-1:0]  pos;
    logic [WORD_W-1:0] value;
  } ils_cmd_t;

endpackage

// ----- src/ils_if.sv -----
// ----------------------------------------------------------------------------
// ils_if: channel interfaces of the indexed list store
// One interface for the operation words coming in, one for result words.
// ----------------------------------------------------------------------------
interface ils_in_if import ils_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [IDX_W-1:0]  index;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output operation, output index, output value,
                  input ready);
  modport sink   (input valid, input operation, input index, input value,
                  output ready);
endinterface

interface ils_out_if import ils_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] read_value;
  logic [ST_W-1:0]          status;
  logic [LEN_W-1:0]         length;

  modport source (output valid, output read_value, output status, output length,
                  input ready);
  modport sink   (input valid, input read_value, input status, input length,
                  output ready);
endinterface

// ----- src/indexed_list_store.sv -----
// ----------------------------------------------------------------------------
// indexed_list_store: ordered list of signed words with indexed access
// Get, insert at head, tail or position, and delete at position, over a row
// of entry cells that shift in parallel.
// ----------------------------------------------------------------------------
//  channel  | dir | fields
//  ---------+-----+-------------------------------------------
//  in_ch    | in  | operation[2:0], index[7:0] s, value[31:0] s
//  out_ch   | out | read_value[31:0] s, status[1:0], length[6:0]
//
//  Each word passes through decode at accept, a shift step in which all
//  cells shift at once and the read hits are grouped into registers, and
//  a step that combines the groups into the result register.
//  A new word is accepted while the previous result still waits in the
//  output register; a stalled output holds the block in its last step.
//  Synchronous active-low reset empties the list; entry words are not reset.
// ----------------------------------------------------------------------------
module indexed_list_store import ils_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ils_in_if.sink     in_ch,
  ils_out_if.source  out_ch
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DONE} state_t;

  state_t            state_r;
  ils_cmd_t          cmd_r;
  ils_cmd_t          cmd_nxt;
  ils_cmd_t          exec_cmd;
  logic [ST_W-1:0]   st_r;
  logic [ST_W-1:0]   st_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_rd_r;
  logic [ST_W-1:0]   out_st_r;
  logic [LEN_W-1:0]  out_len_r;
  logic [WORD_W-1:0] rd_word;
  logic              accept;
  logic              out_free;
  logic              idx_neg;
  logic [CMP_W-1:0]  idx_u;
  logic [CMP_W-1:0]  cnt_e;
  logic              in_range;
  logic              full;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Decode the incoming word against the current length
  assign idx_neg  = in_ch.index[IDX_W-1];
  assign idx_u    = CMP_W'(in_ch.index[IDX_W-2:0]);
  assign cnt_e    = CMP_W'(count_r);
  assign in_range = !idx_neg && (idx_u < cnt_e);
  assign full     = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    cmd_nxt            = '0;
    cmd_nxt.value      = in_ch.value;
    st_nxt             = ST_DONE;
    unique case (in_ch.operation)
      OP_GET: begin
        if (in_range) begin
          cmd_nxt.rd_en = 1'b1;
          cmd_nxt.pos   = idx_u[CNT_W-1:0];
        end else begin
          st_nxt = ST_RANGE;
        end
      end
      OP_INS_HEAD: begin
        if (full) begin
          st_nxt = ST_FULL;
        end else begin
          cmd_nxt.shift_up = 1'b1;
          cmd_nxt.pos      = '0;
        end
      end
      OP_INS_TAIL: begin
        if (full) begin
          st_nxt = ST_FULL;
        end else begin
          cmd_nxt.shift_up = 1'b1;
          cmd_nxt.pos      = count_r;
        end
      end
      OP_INS_POS: begin
        if (idx_neg) begin
          if (full) begin
            st_nxt = ST_FULL;
          end else begin
            cmd_nxt.shift_up = 1'b1;
            cmd_nxt.pos      = '0;
          end
        end else if (idx_u > cnt_e) begin
          st_nxt = ST_RANGE;
        end else if (full) begin
          st_nxt = ST_FULL;
        end else begin
          cmd_nxt.shift_up = 1'b1;
          cmd_nxt.pos      = idx_u[CNT_W-1:0];
        end
      end
      OP_DELETE: begin
        if (in_range) begin
          cmd_nxt.shift_down = 1'b1;
          cmd_nxt.pos        = idx_u[CNT_W-1:0];
        end else begin
          st_nxt = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  // Adjust the length for a shift
  always_comb begin
    count_nxt = count_r;
    if (cmd_nxt.shift_up) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd_nxt.shift_down) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Shift the cells only in the shift cycle; hold the read select until the
  // result register takes the read word
  always_comb begin
    exec_cmd = cmd_r;
    if (state_r != S_EXEC) begin
      exec_cmd.shift_up   = 1'b0;
      exec_cmd.shift_down = 1'b0;
    end
    if (state_r == S_IDLE) begin
      exec_cmd.rd_en      = 1'b0;
    end
  end

  ils_chain u_chain (
    .clk     (clk),
    .cmd     (exec_cmd),
    .rd_word (rd_word)
  );

  // Sequence each word and hold the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      count_r          <= '0;
      cmd_r.shift_up   <= 1'b0;
      cmd_r.shift_down <= 1'b0;
      cmd_r.rd_en      <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r   <= cmd_nxt;
            st_r    <= st_nxt;
            count_r <= count_nxt;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_rd_r    <= cmd_r.rd_en ? rd_word : '1;
            out_st_r    <= st_r;
            out_len_r   <= LEN_W'(count_r);
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_rd_r;
  assign out_ch.status     = out_st_r;
  assign out_ch.length     = out_len_r;

endmodule

// ----- src/ils_cell.sv -----
// ----------------------------------------------------------------------------
// ils_cell: one entry of the list
// Holds one word; on an insert shift takes the insert word or its lower
// neighbor's, on a delete its upper neighbor's, and offers it on a read hit.
// ----------------------------------------------------------------------------
module ils_cell import ils_pkg::*; (
  input  logic              clk,
  input  logic [CNT_W-1:0]  cell_idx,
  input  ils_cmd_t          cmd,
  input  logic [WORD_W-1:0] prev_word,
  input  logic [WORD_W-1:0] next_word,
  output logic [WORD_W-1:0] word_o,
  output logic [WORD_W-1:0] rd_o
);

  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] data_nxt;

  // Select the next word from the broadcast command
  always_comb begin
    data_nxt = data_r;
    if (cmd.shift_up) begin
      if (cell_idx > cmd.pos) begin
        data_nxt = prev_word;
      end else if (cell_idx == cmd.pos) begin
        data_nxt = cmd.value;
      end
    end else if (cmd.shift_down && (cell_idx >= cmd.pos)) begin
      data_nxt = next_word;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign word_o = data_r;
  assign rd_o   = (cmd.rd_en && (cell_idx == cmd.pos)) ? data_r : '0;

endmodule

// ----- src/ils_chain.sv -----
// ----------------------------------------------------------------------------
// ils_chain: row of entry cells with a registered read tree
// Links each cell to its neighbors and ORs the read hits into one register
// per group of cells.
// ----------------------------------------------------------------------------
module ils_chain import ils_pkg::*; (
  input  logic              clk,
  input  ils_cmd_t          cmd,
  output logic [WORD_W-1:0] rd_word
);

  logic [WORD_W-1:0] cell_word [CAPACITY];
  logic [WORD_W-1:0] cell_rd   [CAPACITY];
  logic [WORD_W-1:0] grp_nxt   [NGRP];
  logic [WORD_W-1:0] grp_r     [NGRP];

  // Build the row; the ends see the insert word and zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] prev_w;
    logic [WORD_W-1:0] next_w;
    if (i == 0) begin : g_first
      assign prev_w = cmd.value;
    end else begin : g_mid_lo
      assign prev_w = cell_word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_mid_hi
      assign next_w = cell_word[i+1];
    end
    ils_cell u_cell (
      .clk       (clk),
      .cell_idx  (CNT_W'(i)),
      .cmd       (cmd),
      .prev_word (prev_w),
      .next_word (next_w),
      .word_o    (cell_word[i]),
      .rd_o      (cell_rd[i])
    );
  end

  // OR the read hits within each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int m = 0; m < GRP_SIZE; m++) begin
        if (g * GRP_SIZE + m < CAPACITY) begin
          grp_nxt[g] = grp_nxt[g] | cell_rd[g * GRP_SIZE + m];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_r[g] <= grp_nxt[g];
    end
  end

  // Combine the group registers
  always_comb begin
    rd_word = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_word = rd_word | grp_r[g];
    end
  end

endmodule
